>>> sv/eas_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command and status types for the encoder angle to scroll steps block.
// No dependencies.
package eas_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 12;
  localparam int unsigned DIV_W          = 13;
  localparam int unsigned DIV_MAX        = 4096;
  localparam int unsigned STEPS_W        = 14;
  localparam int unsigned STEP_MAX       = 8191;
  localparam int unsigned STEP_MIN_MAG   = 8192;

  // The accumulator must hold a remainder of up to 4095 plus a half turn of delta.
  function automatic int unsigned eas_acc_width(input int unsigned angle_bits);
    return (angle_bits > 12) ? angle_bits + 1 : 14;
  endfunction

  typedef struct packed {
    logic capture;
    logic sum;
    logic div_step;
    logic finish;
    logic load_out;
  } eas_cmd_t;

  typedef struct packed {
    logic go;
    logic has_result;
  } eas_sts_t;

endpackage

>>> sv/eas_angle_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries one angle sample per item.
// No dependencies.
interface eas_angle_if #(
  parameter int unsigned AngleBits = 12
);
  logic                 valid;
  logic                 ready;
  logic [AngleBits-1:0] angle_sample;

  modport source (output valid, output angle_sample, input ready);
  modport sink (input valid, input angle_sample, output ready);
endinterface

>>> sv/eas_steps_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries one signed scroll step count per item.
// Depends on eas_pkg for the field width.
interface eas_steps_if
  import eas_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [STEPS_W-1:0] scroll_steps;

  modport source (output valid, output scroll_steps, input ready);
  modport sink (input valid, input scroll_steps, output ready);
endinterface

>>> sv/eas_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences capture, sum, bit-serial divide and output load.
// Depends on eas_pkg for the command and status types.
module eas_ctrl
  import eas_pkg::*;
#(
  parameter int unsigned AccW = 14
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  eas_sts_t sts_i,
  output eas_cmd_t cmd_o
);

  localparam int unsigned CntW = $clog2(AccW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            in_ready_q;
  logic            out_valid_q;
  logic            out_free;
  logic            accept;

  assign accept   = in_valid_i && in_ready_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept;
    cmd_o.sum      = (state_q == S_SUM);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.finish   = (state_q == S_FIN);
    cmd_o.load_out = (state_q == S_EMIT) && sts_i.has_result && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && sts_i.go) begin
            state_q    <= S_SUM;
            in_ready_q <= 1'b0;
          end
        end
        S_SUM: begin
          state_q <= S_DIV;
          cnt_q   <= CntW'(AccW - 1);
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_FIN: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!sts_i.has_result || out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/eas_datapath.sv
`timescale 1ns / 1ps
// Datapath: angle delta wrap, remainder accumulator, radix-2 magnitude divider and result register.
// Depends on eas_pkg for constants and the command and status types.
module eas_datapath
  import eas_pkg::*;
#(
  parameter int unsigned AngleBits = ANGLE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [DIV_W-1:0]          cfg_wdata_i,
  input  logic [AngleBits-1:0]      angle_i,
  input  eas_cmd_t                  cmd_i,
  output eas_sts_t                  sts_o,
  output logic signed [STEPS_W-1:0] steps_o
);

  localparam int unsigned AccW   = eas_acc_width(AngleBits);
  localparam int unsigned DeltaW = AngleBits + 1;
  localparam int unsigned WideW  = AngleBits + 2;

  logic [AngleBits-1:0]     prev_q;
  logic                     primed_q;
  logic signed [AccW-1:0]   acc_q;
  logic [DIV_W-1:0]         div_q;
  logic signed [DeltaW-1:0] delta_q;
  logic                     neg_q;
  logic [AccW-1:0]          num_q;
  logic [DIV_W-1:0]         rem_q;
  logic signed [STEPS_W-1:0] steps_q;

  logic signed [WideW-1:0]  diff;
  logic signed [WideW-1:0]  wrapped;
  logic signed [AccW-1:0]   sum;
  logic [DIV_W:0]           trial;
  logic [DIV_W:0]           trial_sub;
  logic                     trial_ge;
  logic [AccW-1:0]          rem_ext;
  logic [STEPS_W-1:0]       mag_sat;

  localparam logic signed [WideW-1:0] Half = WideW'(1) <<< (AngleBits - 1);
  localparam logic signed [WideW-1:0] Full = WideW'(1) <<< AngleBits;

  always_comb begin
    diff = WideW'($signed({2'b00, prev_q})) - WideW'($signed({2'b00, angle_i}));
    if (diff > Half) begin
      wrapped = diff - Full;
    end else if (diff < -Half) begin
      wrapped = diff + Full;
    end else begin
      wrapped = diff;
    end
  end

  assign sum       = acc_q - AccW'(delta_q);
  assign trial     = {rem_q, num_q[AccW-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign trial_ge  = (trial >= {1'b0, div_q});
  assign rem_ext   = AccW'(rem_q);

  always_comb begin
    if (neg_q) begin
      mag_sat = (num_q > AccW'(STEP_MIN_MAG)) ? STEPS_W'(STEP_MIN_MAG) : num_q[STEPS_W-1:0];
    end else begin
      mag_sat = (num_q > AccW'(STEP_MAX)) ? STEPS_W'(STEP_MAX) : num_q[STEPS_W-1:0];
    end
  end

  assign sts_o.go         = primed_q && (wrapped != '0);
  assign sts_o.has_result = (num_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      primed_q <= 1'b0;
      acc_q    <= '0;
      div_q    <= DIV_W'(1);
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0) begin
          div_q <= DIV_W'(1);
        end else if (cfg_wdata_i > DIV_W'(DIV_MAX)) begin
          div_q <= DIV_W'(DIV_MAX);
        end else begin
          div_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.capture) begin
        prev_q   <= angle_i;
        primed_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        acc_q <= neg_q ? -$signed(rem_ext) : $signed(rem_ext);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      delta_q <= wrapped[DeltaW-1:0];
    end
    if (cmd_i.sum) begin
      neg_q <= sum[AccW-1];
      num_q <= sum[AccW-1] ? AccW'(-sum) : AccW'(sum);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[AccW-2:0], trial_ge};
      rem_q <= trial_ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
    end
    if (cmd_i.load_out) begin
      steps_q <= neg_q ? -$signed(mag_sat) : $signed(mag_sat);
    end
  end

  assign steps_o = steps_q;

endmodule

>>> sv/encoder_angle_to_scroll_steps.sv
`timescale 1ns / 1ps
// A sample that yields steps passes through the sum, divide, finish and emit states after
// acceptance; the radix-2 divider produces one quotient bit per cycle over the AccW-bit
// accumulator, and the emit state waits while the output holds an untaken result. One item
// is in work at a time; a priming sample or zero delta skips the divider and leaves the input ready.
// Reset clears the previous angle, the primed flag and the accumulator, and sets the divider to 1.
// Top level; depends on eas_pkg, eas_angle_if, eas_steps_if, eas_ctrl and eas_datapath.
module encoder_angle_to_scroll_steps
  import eas_pkg::*;
#(
  parameter int unsigned AngleBits = ANGLE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [DIV_W-1:0] cfg_wdata_i,
  eas_angle_if.sink        angle_i,
  eas_steps_if.source      steps_o
);

  localparam int unsigned AccW = eas_acc_width(AngleBits);

  eas_cmd_t cmd;
  eas_sts_t sts;

  eas_ctrl #(
    .AccW (AccW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (angle_i.valid),
    .in_ready_o  (angle_i.ready),
    .out_valid_o (steps_o.valid),
    .out_ready_i (steps_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  eas_datapath #(
    .AngleBits (AngleBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .angle_i     (angle_i.angle_sample),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .steps_o     (steps_o.scroll_steps)
  );

endmodule

>>> sim/encoder_angle_to_scroll_steps_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for encoder_angle_to_scroll_steps: angle samples go in over a
// valid/ready channel and every scroll step item is checked against an in-bench predictor.
// Depends on eas_pkg, eas_angle_if, eas_steps_if and the block itself.
module encoder_angle_to_scroll_steps_tb;
  import eas_pkg::*;

  localparam int unsigned ANGLE_W = ANGLE_BITS_DEF;
  localparam int ANGLE_FULL = 1 << ANGLE_W;
  localparam int HALF_TURN = ANGLE_FULL / 2;
  localparam int SETTLE_CYCLES = 26;
  localparam int WATCHDOG_LIMIT = 3000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [DIV_W-1:0] cfg_wdata;

  eas_angle_if #(.AngleBits(ANGLE_W)) angle_ch ();
  eas_steps_if steps_ch ();

  encoder_angle_to_scroll_steps #(
    .AngleBits(ANGLE_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .angle_i    (angle_ch),
    .steps_o    (steps_ch)
  );

  logic [ANGLE_W-1:0]        last_angle_q = '0;
  logic                      primed_q = 1'b0;
  int                        remainder_q = 0;
  logic [DIV_W-1:0]          divider_q = 1;
  logic signed [STEPS_W-1:0] pending_steps[$];
  logic signed [STEPS_W-1:0] expected_steps;
  logic [ANGLE_W-1:0]        last_sent = '0;
  int                        send_idle_pct = 0;
  int                        recv_stall_pct = 0;
  int                        error_count = 0;
  int                        quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_steps(input logic [ANGLE_W-1:0] sample);
    int delta;
    int div;
    int quotient;
    if (!primed_q) begin
      primed_q = 1'b1;
      last_angle_q = sample;
      return;
    end
    delta = int'(last_angle_q) - int'(sample);
    if (delta > HALF_TURN) begin
      delta -= ANGLE_FULL;
    end else if (delta < -HALF_TURN) begin
      delta += ANGLE_FULL;
    end
    last_angle_q = sample;
    if (delta == 0) return;
    div = int'(divider_q);
    if (div < 1) div = 1;
    if (div > int'(DIV_MAX)) div = int'(DIV_MAX);
    remainder_q -= delta;
    quotient = remainder_q / div;
    remainder_q = remainder_q % div;
    if (quotient == 0) return;
    if (quotient > int'(STEP_MAX)) quotient = int'(STEP_MAX);
    if (quotient < -int'(STEP_MIN_MAG)) quotient = -int'(STEP_MIN_MAG);
    pending_steps.push_back(quotient[STEPS_W-1:0]);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (steps_ch.valid && steps_ch.ready) begin
        if (pending_steps.size() == 0) begin
          report_mismatch($sformatf("unexpected scroll_steps %0d", steps_ch.scroll_steps));
        end else begin
          expected_steps = pending_steps.pop_front();
          if (steps_ch.scroll_steps !== expected_steps) begin
            report_mismatch($sformatf("scroll_steps %0d, expected %0d",
                                      steps_ch.scroll_steps, expected_steps));
          end
        end
      end
      if (angle_ch.valid && angle_ch.ready) predict_steps(angle_ch.angle_sample);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (angle_ch.valid && angle_ch.ready) ||
        (steps_ch.valid && steps_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[encoder_angle_to_scroll_steps] ERROR");
        $finish;
      end
    end
  end

  initial begin
    steps_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      steps_ch.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_angle(input logic [ANGLE_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      angle_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.angle_sample <= sample;
    last_sent = sample;
    @(posedge clk_i);
    while (!angle_ch.ready) @(posedge clk_i);
  endtask

  task automatic stop_sending();
    angle_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_divider(input logic [DIV_W-1:0] value);
    stop_sending();
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    divider_q = value;
  endtask

  // Mostly steady rotation in one direction with occasional reversals, plus fast moves,
  // exact half turns, repeated angles and arbitrary jumps.
  task automatic send_motion(input int count);
    int dir;
    int kind;
    int step;
    dir = 1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) dir = -dir;
      kind = $urandom_range(99);
      if (kind < 70) begin
        step = dir * int'($urandom_range(400));
      end else if (kind < 80) begin
        step = dir * int'($urandom_range(HALF_TURN - 1));
      end else if (kind < 86) begin
        step = dir * HALF_TURN;
      end else if (kind < 92) begin
        step = 0;
      end else begin
        step = int'($urandom_range(ANGLE_FULL - 1));
      end
      send_angle(ANGLE_W'((int'(last_sent) + step) & (ANGLE_FULL - 1)));
    end
  endtask

  // The first sample only primes; rollover both ways, half turns kept as they are, zero delta.
  task automatic test_priming_and_wrap();
    send_angle(12'd4095);
    send_angle(12'd0);
    send_angle(12'd2048);
    send_angle(12'd0);
    send_angle(12'd0);
    send_angle(12'd4095);
    send_angle(12'd2047);
    send_angle(12'd4095);
    send_angle(12'hAAA);
    send_angle(12'h555);
    stop_sending();
    wait_drained();
  endtask

  // Largest divider, out-of-range divider values, and negative remainders with a small one.
  task automatic test_divider_limits();
    write_divider(13'd4096);
    send_angle(12'd0);
    send_angle(12'd2047);
    send_angle(12'd4094);
    send_angle(12'd1);
    send_angle(12'd2049);
    send_angle(12'd1);
    write_divider(13'd0);
    send_angle(12'd100);
    send_angle(12'd90);
    write_divider(13'd8191);
    send_angle(12'd2148);
    send_angle(12'd100);
    write_divider(13'd3);
    send_angle(12'd110);
    send_angle(12'd105);
    send_angle(12'd104);
    send_angle(12'd100);
    send_angle(12'd101);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random_motion();
    logic [DIV_W-1:0] div;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct = 27;
          recv_stall_pct = 27;
        end
      endcase
      for (int d = 0; d < 4; d++) begin
        case ($urandom_range(8))
          0: div = 13'd1;
          1: div = 13'd2;
          2: div = DIV_W'($urandom_range(1, 16));
          3: div = DIV_W'($urandom_range(1, 256));
          4: div = DIV_W'($urandom_range(1, 4096));
          5: div = 13'd4096;
          6: div = 13'd0;
          7: div = 13'd8191;
          default: div = DIV_W'($urandom_range(8191));
        endcase
        write_divider(div);
        send_motion(80);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    angle_ch.valid = 1'b0;
    angle_ch.angle_sample = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_priming_and_wrap();
    test_divider_limits();
    test_random_motion();
    stop_sending();
    wait_drained();
    if (error_count == 0) begin
      $display("[encoder_angle_to_scroll_steps] OK");
    end else begin
      $display("[encoder_angle_to_scroll_steps] ERROR");
    end
    $finish;
  end

endmodule
